/* rtl/core/pbmm_pkg.sv */
// ============================================================================
// pbmm_pkg
// Shared constants, command and state codes, and the pair address function
// of the pair boundary mean merge table.
// ============================================================================
package pbmm_pkg;

    localparam int LABEL_BITS    = 6;
    localparam int BOUNDARY_BITS = 8;
    localparam int COUNT_BITS    = 24;
    localparam int SUM_BITS      = 32;
    localparam int MEAN_BITS     = 16;
    localparam int FRAC_BITS     = 8;
    localparam int PAIR_BITS     = 2 * LABEL_BITS;
    localparam int PAIR_DEPTH    = 1 << PAIR_BITS;
    localparam int ENTRY_BITS    = COUNT_BITS + SUM_BITS;
    localparam int QBIT_BITS     = $clog2(MEAN_BITS);

    localparam logic [MEAN_BITS-1:0] THRESH_RESET = 16'h8000;

    typedef enum logic [1:0] {
        CMD_ACCUM = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_UNITE = 2'd2,
        CMD_MOVE  = 2'd3
    } t_cmd;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_READ2 = 5'b01000,
        ST_DIV   = 5'b10000
    } t_state;

    // unordered pair -> one entry: (min << LABEL_BITS) | max
    function automatic logic [PAIR_BITS-1:0] pair_index(
        input logic [LABEL_BITS-1:0] x,
        input logic [LABEL_BITS-1:0] y
    );
        logic [LABEL_BITS-1:0] lo;
        logic [LABEL_BITS-1:0] hi;
        lo = (x < y) ? x : y;
        hi = (x < y) ? y : x;
        return {lo, hi};
    endfunction

endpackage

/* rtl/core/pbmm_ram.sv */
// ============================================================================
// pbmm_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ============================================================================
module pbmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/pair_boundary_mean_merge_table_unit.sv */
// ============================================================================
// pair_boundary_mean_merge_table_unit
// Per-pair boundary sum/count table in one RAM, with accumulate, mean query
// against a merge threshold, and unite/move of neighbor entries.
// ============================================================================
// Accumulate and move finish after one RAM read; unite does two reads on the one
// RAM read port; a query finishes early when the pair is empty or the mean is at
// least 256.0, else it runs the radix-2 divider, one quotient bit per cycle.
// busy drops as the result strobe rises, so a new item is taken only once the
// last one is through. After reset a clearing pass writes all 4096 entries
// to zero with busy high; config writes are always taken.
module pair_boundary_mean_merge_table_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_cmd,
    input  logic [pbmm_pkg::LABEL_BITS-1:0]     i_label_a,
    input  logic [pbmm_pkg::LABEL_BITS-1:0]     i_label_b,
    input  logic [pbmm_pkg::LABEL_BITS-1:0]     i_label_c,
    input  logic [pbmm_pkg::BOUNDARY_BITS-1:0]  i_boundary_value,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pbmm_pkg::MEAN_BITS-1:0]      i_cfg_merge_threshold,
    output logic                                o_valid,
    output logic [pbmm_pkg::MEAN_BITS-1:0]      o_mean_priority,
    output logic                                o_pair_empty,
    output logic                                o_merge_ok
);

    pbmm_pkg::t_state                     r_state, n_state;
    logic [pbmm_pkg::PAIR_BITS-1:0]       r_clr_addr, n_clr_addr;
    logic [pbmm_pkg::MEAN_BITS-1:0]       r_thresh;
    pbmm_pkg::t_cmd                       r_cmd, n_cmd;
    logic [pbmm_pkg::PAIR_BITS-1:0]       r_ks, n_ks;
    logic [pbmm_pkg::PAIR_BITS-1:0]       r_kt, n_kt;
    logic [pbmm_pkg::BOUNDARY_BITS-1:0]   r_sample, n_sample;
    logic [pbmm_pkg::ENTRY_BITS-1:0]      r_src, n_src;
    logic [pbmm_pkg::COUNT_BITS-1:0]      r_div, n_div;
    logic [pbmm_pkg::COUNT_BITS-1:0]      r_rem, n_rem;
    logic [pbmm_pkg::MEAN_BITS-1:0]       r_lo, n_lo;
    logic [pbmm_pkg::MEAN_BITS-1:0]       r_quo, n_quo;
    logic [pbmm_pkg::QBIT_BITS-1:0]       r_bit, n_bit;
    logic                                 r_out_valid, n_out_valid;
    logic [pbmm_pkg::MEAN_BITS-1:0]       r_mean, n_mean;
    logic                                 r_empty, n_empty;
    logic                                 r_ok, n_ok;

    logic                                 mem_we;
    logic [pbmm_pkg::PAIR_BITS-1:0]       mem_waddr;
    logic [pbmm_pkg::ENTRY_BITS-1:0]      mem_wdata;
    logic [pbmm_pkg::PAIR_BITS-1:0]       mem_raddr;
    logic [pbmm_pkg::ENTRY_BITS-1:0]      mem_rdata;

    logic [pbmm_pkg::PAIR_BITS-1:0]       w_idx_ab;
    logic [pbmm_pkg::PAIR_BITS-1:0]       w_idx_ac;
    logic [pbmm_pkg::SUM_BITS-1:0]        w_rd_sum;
    logic [pbmm_pkg::COUNT_BITS-1:0]      w_rd_count;
    logic [pbmm_pkg::SUM_BITS-1:0]        w_src_sum;
    logic [pbmm_pkg::COUNT_BITS-1:0]      w_src_count;
    logic [pbmm_pkg::SUM_BITS:0]          w_acc_sum;
    logic [pbmm_pkg::COUNT_BITS-1:0]      w_cnt_inc;
    logic [pbmm_pkg::SUM_BITS:0]          w_uni_sum;
    logic [pbmm_pkg::COUNT_BITS:0]        w_uni_count;
    logic [pbmm_pkg::SUM_BITS-1:0]        w_sat_sum;
    logic [pbmm_pkg::COUNT_BITS-1:0]      w_sat_count;
    logic [pbmm_pkg::COUNT_BITS+pbmm_pkg::FRAC_BITS-1:0] w_cnt_sh;
    logic [pbmm_pkg::COUNT_BITS:0]        w_trial;
    logic [pbmm_pkg::COUNT_BITS:0]        w_diff;
    logic                                 w_qbit;
    logic [pbmm_pkg::MEAN_BITS-1:0]       w_quo_fin;

    pbmm_ram #(
        .WIDTH (pbmm_pkg::ENTRY_BITS),
        .DEPTH (pbmm_pkg::PAIR_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign w_idx_ab = pbmm_pkg::pair_index(i_label_a, i_label_b);
    assign w_idx_ac = pbmm_pkg::pair_index(i_label_a, i_label_c);

    // second read of a unite goes to the target entry
    assign mem_raddr = (r_state == pbmm_pkg::ST_IDLE) ? w_idx_ab : r_kt;

    // entry layout: {count, sum}
    assign w_rd_sum    = mem_rdata[pbmm_pkg::SUM_BITS-1:0];
    assign w_rd_count  = mem_rdata[pbmm_pkg::ENTRY_BITS-1:pbmm_pkg::SUM_BITS];
    assign w_src_sum   = r_src[pbmm_pkg::SUM_BITS-1:0];
    assign w_src_count = r_src[pbmm_pkg::ENTRY_BITS-1:pbmm_pkg::SUM_BITS];

    assign w_acc_sum   = {1'b0, w_rd_sum} + {{(pbmm_pkg::SUM_BITS + 1
                         - pbmm_pkg::BOUNDARY_BITS){1'b0}}, r_sample};
    assign w_cnt_inc   = w_rd_count + 1'b1;

    assign w_uni_sum   = {1'b0, w_rd_sum} + {1'b0, w_src_sum};
    assign w_uni_count = {1'b0, w_rd_count} + {1'b0, w_src_count};
    assign w_sat_sum   = w_uni_sum[pbmm_pkg::SUM_BITS] ? '1
                                                        : w_uni_sum[pbmm_pkg::SUM_BITS-1:0];
    assign w_sat_count = w_uni_count[pbmm_pkg::COUNT_BITS] ? '1
                                                        : w_uni_count[pbmm_pkg::COUNT_BITS-1:0];

    // sum >= count * 256 means the 8.8 mean is 256.0 or more
    assign w_cnt_sh  = {w_rd_count, {pbmm_pkg::FRAC_BITS{1'b0}}};

    // restoring divide step
    assign w_trial   = {r_rem, r_lo[pbmm_pkg::MEAN_BITS-1]};
    assign w_diff    = w_trial - {1'b0, r_div};
    assign w_qbit    = (w_trial >= {1'b0, r_div});
    assign w_quo_fin = {r_quo[pbmm_pkg::MEAN_BITS-2:0], w_qbit};

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_cmd       = r_cmd;
        n_ks        = r_ks;
        n_kt        = r_kt;
        n_sample    = r_sample;
        n_src       = r_src;
        n_div       = r_div;
        n_rem       = r_rem;
        n_lo        = r_lo;
        n_quo       = r_quo;
        n_bit       = r_bit;
        n_out_valid = 1'b0;
        n_mean      = r_mean;
        n_empty     = r_empty;
        n_ok        = r_ok;
        mem_we      = 1'b0;
        mem_waddr   = r_kt;
        mem_wdata   = '0;

        case (r_state)
            pbmm_pkg::ST_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    n_state = pbmm_pkg::ST_IDLE;
                end
            end

            pbmm_pkg::ST_IDLE: begin
                if (start) begin
                    n_cmd    = pbmm_pkg::t_cmd'(i_cmd);
                    n_ks     = w_idx_ab;
                    n_kt     = w_idx_ac;
                    n_sample = i_boundary_value;
                    n_state  = pbmm_pkg::ST_READ;
                end
            end

            pbmm_pkg::ST_READ: begin
                // default finish: non-query result is all zero
                n_out_valid = 1'b1;
                n_mean      = '0;
                n_empty     = 1'b0;
                n_ok        = 1'b0;
                n_state     = pbmm_pkg::ST_IDLE;
                case (r_cmd)
                    pbmm_pkg::CMD_ACCUM: begin
                        // saturated count or sum overflow: entry frozen
                        if (w_rd_count != '1 && !w_acc_sum[pbmm_pkg::SUM_BITS]) begin
                            mem_we    = 1'b1;
                            mem_waddr = r_ks;
                            mem_wdata = {w_cnt_inc, w_acc_sum[pbmm_pkg::SUM_BITS-1:0]};
                        end
                    end
                    pbmm_pkg::CMD_QUERY: begin
                        if (w_rd_count == '0) begin
                            n_mean  = '1;
                            n_empty = 1'b1;
                        end else if (w_rd_sum >= w_cnt_sh) begin
                            // mean >= 256.0, above any threshold
                            n_mean = '1;
                        end else begin
                            n_out_valid = 1'b0;
                            n_div   = w_rd_count;
                            n_rem   = w_rd_sum[pbmm_pkg::SUM_BITS-1:pbmm_pkg::FRAC_BITS];
                            n_lo    = {w_rd_sum[pbmm_pkg::FRAC_BITS-1:0],
                                       {pbmm_pkg::FRAC_BITS{1'b0}}};
                            n_quo   = '0;
                            n_bit   = '1;
                            n_state = pbmm_pkg::ST_DIV;
                        end
                    end
                    pbmm_pkg::CMD_UNITE: begin
                        n_out_valid = 1'b0;
                        n_src       = mem_rdata;
                        n_state     = pbmm_pkg::ST_READ2;
                    end
                    pbmm_pkg::CMD_MOVE: begin
                        mem_we    = 1'b1;
                        mem_waddr = r_kt;
                        mem_wdata = mem_rdata;
                    end
                    default: begin
                    end
                endcase
            end

            pbmm_pkg::ST_READ2: begin
                mem_we      = 1'b1;
                mem_waddr   = r_kt;
                mem_wdata   = {w_sat_count, w_sat_sum};
                n_out_valid = 1'b1;
                n_mean      = '0;
                n_empty     = 1'b0;
                n_ok        = 1'b0;
                n_state     = pbmm_pkg::ST_IDLE;
            end

            pbmm_pkg::ST_DIV: begin
                n_rem = w_qbit ? w_diff[pbmm_pkg::COUNT_BITS-1:0]
                               : w_trial[pbmm_pkg::COUNT_BITS-1:0];
                n_lo  = {r_lo[pbmm_pkg::MEAN_BITS-2:0], 1'b0};
                n_quo = w_quo_fin;
                n_bit = r_bit - 1'b1;
                if (r_bit == '0) begin
                    n_out_valid = 1'b1;
                    n_mean      = w_quo_fin;
                    n_empty     = 1'b0;
                    n_ok        = (w_quo_fin < r_thresh);
                    n_state     = pbmm_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = pbmm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pbmm_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_thresh    <= pbmm_pkg::THRESH_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_thresh <= i_cfg_merge_threshold;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_ks     <= n_ks;
        r_kt     <= n_kt;
        r_sample <= n_sample;
        r_src    <= n_src;
        r_div    <= n_div;
        r_rem    <= n_rem;
        r_lo     <= n_lo;
        r_quo    <= n_quo;
        r_bit    <= n_bit;
        r_mean   <= n_mean;
        r_empty  <= n_empty;
        r_ok     <= n_ok;
    end

    assign busy            = (r_state != pbmm_pkg::ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_valid         = r_out_valid;
    assign o_mean_priority = r_mean;
    assign o_pair_empty    = r_empty;
    assign o_merge_ok      = r_ok;

endmodule
